// File: rtl/bur_pkg.sv
// shared types and constants for the bounded undo/redo history
package bur_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int BOARD_BITS_DEF = 64;

	// apb register map, one 32-bit register per word
	localparam int         CFG_AW          = 3;
	localparam logic [0:0] REG_MAX_HISTORY = 1'b0;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_UNDO  = 2'd1,
		MODE_REDO  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

// File: rtl/bur_ram.sv
// generic single-write, single-read ram with registered read data
module bur_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// File: rtl/bur_ctrl.sv
// controller: item sequencing and output valid
module bur_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output bur_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_RESULT) && out_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					// memory read data is valid here; wait for a free output slot
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/bur_dp.sv
// datapath: stack stores, pointers, counts, limit register and result register
module bur_dp #(
	parameter int DEPTH      = bur_pkg::DEPTH_DEF,
	parameter int BOARD_BITS = bur_pkg::BOARD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bur_pkg::cmd_t cmd,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	output logic [6:0]    max_history,
	input  logic [1:0]    mode,
	input  logic [63:0]   board_word,
	input  logic [3:0]    blank_x,
	input  logic [3:0]    blank_y,
	input  logic [15:0]   moves_made,
	output logic          has_state,
	output logic          refused,
	output logic [63:0]   out_board,
	output logic [3:0]    out_x,
	output logic [3:0]    out_y,
	output logic [15:0]   out_moves,
	output logic [6:0]    undo_depth,
	output logic [6:0]    redo_depth
);

	localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int EW     = BOARD_BITS + 24;
	localparam int X_LSB  = BOARD_BITS;
	localparam int Y_LSB  = BOARD_BITS + 4;
	localparam int MV_LSB = BOARD_BITS + 8;

	// control state
	logic [6:0]    max_history_q;
	logic          trim_q;
	logic [PW-1:0] utop_q, rtop_q;
	logic [CW-1:0] ucnt_q, rcnt_q;

	// captured item
	bur_pkg::mode_t mode_q;
	logic [EW-1:0]  entry_q;

	// result register
	logic          has_q, refused_q;
	logic [EW-1:0] res_q;
	logic [CW-1:0] ud_q, rd_q;

	// memory ports
	logic [EW-1:0] undo_top_rd, undo_below_rd, redo_top_rd;
	logic          undo_we, redo_we;
	logic [EW-1:0] undo_wdata;
	logic [PW-1:0] utop_inc, utop_dec, rtop_inc, rtop_dec;

	// next-state values
	logic [CW-1:0] lim, ucnt_t, rcnt_t;
	logic [CW:0]   ucnt_inc, rcnt_inc;
	logic [CW-1:0] ucnt_d, rcnt_d;
	logic [PW-1:0] utop_d, rtop_d;
	logic          has_d, refused_d;
	logic [EW-1:0] res_d;

	assign max_history = max_history_q;

	// effective limit: zero or above the store depth means the whole store
	assign lim = (max_history_q == 7'd0 || 32'(max_history_q) > DEPTH)
		? CW'(DEPTH) : CW'(max_history_q);

	assign ucnt_t = (trim_q && ucnt_q > lim) ? lim : ucnt_q;
	assign rcnt_t = (trim_q && rcnt_q > lim) ? lim : rcnt_q;
	assign ucnt_inc = {1'b0, ucnt_t} + (CW+1)'(1);
	assign rcnt_inc = {1'b0, rcnt_t} + (CW+1)'(1);

	assign utop_inc = (utop_q == PW'(DEPTH - 1)) ? '0 : utop_q + PW'(1);
	assign utop_dec = (utop_q == '0) ? PW'(DEPTH - 1) : utop_q - PW'(1);
	assign rtop_inc = (rtop_q == PW'(DEPTH - 1)) ? '0 : rtop_q + PW'(1);
	assign rtop_dec = (rtop_q == '0) ? PW'(DEPTH - 1) : rtop_q - PW'(1);

	always_comb begin
		ucnt_d     = ucnt_t;
		rcnt_d     = rcnt_t;
		utop_d     = utop_q;
		rtop_d     = rtop_q;
		has_d      = 1'b0;
		refused_d  = 1'b0;
		res_d      = '0;
		undo_we    = 1'b0;
		redo_we    = 1'b0;
		undo_wdata = entry_q;
		case (mode_q)
			bur_pkg::MODE_PUSH: begin
				undo_we = 1'b1;
				utop_d  = utop_inc;
				ucnt_d  = (ucnt_inc > {1'b0, lim}) ? lim : ucnt_inc[CW-1:0];
				rcnt_d  = '0;
			end
			bur_pkg::MODE_UNDO: begin
				if (ucnt_t == '0) begin
					refused_d = 1'b1;
				end else begin
					redo_we = 1'b1;
					utop_d  = utop_dec;
					ucnt_d  = ucnt_t - CW'(1);
					rtop_d  = rtop_inc;
					rcnt_d  = (rcnt_inc > {1'b0, lim}) ? lim : rcnt_inc[CW-1:0];
					has_d   = (ucnt_t > CW'(1));
					res_d   = has_d ? undo_below_rd : '0;
				end
			end
			bur_pkg::MODE_REDO: begin
				if (rcnt_t == '0) begin
					refused_d = 1'b1;
				end else begin
					undo_we    = 1'b1;
					undo_wdata = redo_top_rd;
					rtop_d     = rtop_dec;
					rcnt_d     = rcnt_t - CW'(1);
					utop_d     = utop_inc;
					// redo onto undo is capped at the store depth only
					ucnt_d     = (ucnt_inc > (CW+1)'(DEPTH)) ? CW'(DEPTH) : ucnt_inc[CW-1:0];
					has_d      = 1'b1;
					res_d      = redo_top_rd;
				end
			end
			default: begin
				ucnt_d = '0;
				rcnt_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_history_q <= '0;
			trim_q        <= 1'b0;
			utop_q        <= '0;
			rtop_q        <= '0;
			ucnt_q        <= '0;
			rcnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				max_history_q <= cfg_wdata;
				trim_q        <= 1'b1;
			end else if (cmd.commit) begin
				trim_q <= 1'b0;
			end
			if (cmd.commit) begin
				utop_q <= utop_d;
				rtop_q <= rtop_d;
				ucnt_q <= ucnt_d;
				rcnt_q <= rcnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= bur_pkg::mode_t'(mode);
			entry_q <= {moves_made, blank_y, blank_x, board_word[BOARD_BITS-1:0]};
		end
		if (cmd.commit) begin
			has_q     <= has_d;
			refused_q <= refused_d;
			res_q     <= res_d;
			ud_q      <= ucnt_d;
			rd_q      <= rcnt_d;
		end
	end

	// undo store is kept twice so the top and the entry below it read together
	bur_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_undo_top (
		.clk     (clk),
		.we      (undo_we && cmd.commit),
		.waddr   (utop_inc),
		.wdata   (undo_wdata),
		.raddr   (utop_q),
		.rdata_q (undo_top_rd)
	);

	bur_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_undo_below (
		.clk     (clk),
		.we      (undo_we && cmd.commit),
		.waddr   (utop_inc),
		.wdata   (undo_wdata),
		.raddr   (utop_dec),
		.rdata_q (undo_below_rd)
	);

	bur_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_redo (
		.clk     (clk),
		.we      (redo_we && cmd.commit),
		.waddr   (rtop_inc),
		.wdata   (undo_top_rd),
		.raddr   (rtop_q),
		.rdata_q (redo_top_rd)
	);

	assign has_state  = has_q;
	assign refused    = refused_q;
	assign out_board  = 64'(res_q[BOARD_BITS-1:0]);
	assign out_x      = res_q[X_LSB +: 4];
	assign out_y      = res_q[Y_LSB +: 4];
	assign out_moves  = res_q[MV_LSB +: 16];
	assign undo_depth = 7'(ud_q);
	assign redo_depth = 7'(rd_q);

endmodule

// File: rtl/bounded_undo_redo_history_top.sv
// top level of the bounded undo/redo history
//
// usage: items enter on the in_valid/in_ready channel with a mode (push, undo,
// redo, clear) and, for a push, a snapshot (board word, blank cell, move count).
// every item yields exactly one result on out_valid/out_ready: the returned
// snapshot if any, a refused flag, and both stack depths after the item.
// the max_history register sits at apb address 0; a write arms a trim that
// cuts both stacks to the new limit at the start of the next item.
// timing: an item is taken only in the idle state and its result is registered
// from the result state once the output register is free; no new item is taken
// until then. the result state is needed because the stack memories have
// registered read data, captured at the accepting edge and used in that state.
// a result waiting in the output register does not block the next item; that
// item is held in the result state until the output register is free, so a
// stalled receiver holds the block after at most one more item.
// reset clears the pointers, counts, limit register and output valid; the
// stack memories need no clearing since only entries below a count are read.
module bounded_undo_redo_history_top #(
	parameter int DEPTH      = bur_pkg::DEPTH_DEF,
	parameter int BOARD_BITS = bur_pkg::BOARD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [63:0]                board_word,
	input  logic [3:0]                 blank_x,
	input  logic [3:0]                 blank_y,
	input  logic [15:0]                moves_made,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       has_state,
	output logic                       refused,
	output logic [63:0]                out_board,
	output logic [3:0]                 out_x,
	output logic [3:0]                 out_y,
	output logic [15:0]                out_moves,
	output logic [6:0]                 undo_depth,
	output logic [6:0]                 redo_depth,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bur_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	bur_pkg::cmd_t cmd;
	logic          cfg_we;
	logic          reg_hit;
	logic [6:0]    max_history;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == bur_pkg::REG_MAX_HISTORY);
	assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? 32'(max_history) : '0;

	bur_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bur_dp #(.DEPTH(DEPTH), .BOARD_BITS(BOARD_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[6:0]),
		.max_history (max_history),
		.mode        (mode),
		.board_word  (board_word),
		.blank_x     (blank_x),
		.blank_y     (blank_y),
		.moves_made  (moves_made),
		.has_state   (has_state),
		.refused     (refused),
		.out_board   (out_board),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_moves   (out_moves),
		.undo_depth  (undo_depth),
		.redo_depth  (redo_depth)
	);

	// one item in flight: no item is taken in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still in the datapath");

	a_has_or_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(has_state && refused))
		else $error("result both returns a snapshot and is refused");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_state |-> (out_board == '0 && out_moves == '0
			&& out_x == '0 && out_y == '0))
		else $error("snapshot fields not zero when no snapshot returned");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(undo_depth) <= DEPTH && 32'(redo_depth) <= DEPTH))
		else $error("stack depth above store depth");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the bounded undo/redo history block
module tb_top;

	localparam int STACK_DEPTH = bur_pkg::DEPTH_DEF;
	localparam logic [bur_pkg::CFG_AW-1:0] ADDR_MAX_HISTORY =
		bur_pkg::CFG_AW'(4 * bur_pkg::REG_MAX_HISTORY);
	localparam logic [bur_pkg::CFG_AW-1:0] ADDR_UNMAPPED    =
		bur_pkg::CFG_AW'(ADDR_MAX_HISTORY + 4);

	typedef struct packed {
		bur_pkg::mode_t mode;
		logic [63:0]    board;
		logic [3:0]     x;
		logic [3:0]     y;
		logic [15:0]    moves;
	} history_item_t;

	typedef struct packed {
		logic        has_state;
		logic        refused;
		logic [63:0] board;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [15:0] moves;
		logic [6:0]  undo_depth;
		logic [6:0]  redo_depth;
	} history_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [1:0]                   mode;
	logic [63:0]                  board_word;
	logic [3:0]                   blank_x;
	logic [3:0]                   blank_y;
	logic [15:0]                  moves_made;
	logic                         out_valid;
	logic                         out_ready;
	logic                         has_state;
	logic                         refused;
	logic [63:0]                  out_board;
	logic [3:0]                   out_x;
	logic [3:0]                   out_y;
	logic [15:0]                  out_moves;
	logic [6:0]                   undo_depth;
	logic [6:0]                   redo_depth;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [bur_pkg::CFG_AW-1:0]   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	// predicted history state
	logic [63:0] undo_board_q [STACK_DEPTH];
	logic [23:0] undo_extra_q [STACK_DEPTH];
	logic [63:0] redo_board_q [STACK_DEPTH];
	logic [23:0] redo_extra_q [STACK_DEPTH];
	int unsigned undo_top;
	int unsigned undo_cnt;
	int unsigned redo_top;
	int unsigned redo_cnt;
	logic [6:0]  hist_limit;
	bit          trim_armed;

	history_result_t pending_results [$];
	int errors;
	bit idling;
	bit stall_req;
	int stall_left;

	bounded_undo_redo_history_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .board_word(board_word), .blank_x(blank_x), .blank_y(blank_y),
		.moves_made(moves_made),
		.out_valid(out_valid), .out_ready(out_ready),
		.has_state(has_state), .refused(refused), .out_board(out_board),
		.out_x(out_x), .out_y(out_y), .out_moves(out_moves),
		.undo_depth(undo_depth), .redo_depth(redo_depth),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("bounded_undo_redo_history_top: mismatch");
		$finish;
	end

	function automatic int unsigned limit_now();
		if (hist_limit == 0 || hist_limit > STACK_DEPTH)
			return STACK_DEPTH;
		return 32'(hist_limit);
	endfunction

	function automatic void push_undo(logic [63:0] b, logic [23:0] e, int unsigned cap);
		undo_top = (undo_top + 1) % STACK_DEPTH;
		undo_board_q[undo_top] = b;
		undo_extra_q[undo_top] = e;
		if (undo_cnt < STACK_DEPTH)
			undo_cnt++;
		if (undo_cnt > cap)
			undo_cnt = cap;
	endfunction

	function automatic history_result_t predict_history(history_item_t it);
		history_result_t r;
		int unsigned lim;
		logic [63:0] b;
		logic [23:0] e;
		r = '0;
		lim = limit_now();
		// a limit write cuts both stacks before the next item runs
		if (trim_armed) begin
			if (undo_cnt > lim) undo_cnt = lim;
			if (redo_cnt > lim) redo_cnt = lim;
			trim_armed = 1'b0;
		end
		case (it.mode)
			bur_pkg::MODE_PUSH: begin
				push_undo(it.board, {it.moves, it.y, it.x}, lim);
				redo_cnt = 0;
			end
			bur_pkg::MODE_UNDO: begin
				if (undo_cnt == 0) begin
					r.refused = 1'b1;
				end else begin
					b = undo_board_q[undo_top];
					e = undo_extra_q[undo_top];
					undo_top = (undo_top + STACK_DEPTH - 1) % STACK_DEPTH;
					undo_cnt--;
					redo_top = (redo_top + 1) % STACK_DEPTH;
					redo_board_q[redo_top] = b;
					redo_extra_q[redo_top] = e;
					if (redo_cnt < STACK_DEPTH)
						redo_cnt++;
					if (redo_cnt > lim)
						redo_cnt = lim;
					if (undo_cnt > 0) begin
						r.has_state = 1'b1;
						r.board = undo_board_q[undo_top];
						{r.moves, r.y, r.x} = undo_extra_q[undo_top];
					end
				end
			end
			bur_pkg::MODE_REDO: begin
				if (redo_cnt == 0) begin
					r.refused = 1'b1;
				end else begin
					b = redo_board_q[redo_top];
					e = redo_extra_q[redo_top];
					redo_top = (redo_top + STACK_DEPTH - 1) % STACK_DEPTH;
					redo_cnt--;
					// going back onto undo is bounded only by the storage
					push_undo(b, e, STACK_DEPTH);
					r.has_state = 1'b1;
					r.board = b;
					{r.moves, r.y, r.x} = e;
				end
			end
			bur_pkg::MODE_CLEAR: begin
				undo_cnt = 0;
				redo_cnt = 0;
			end
		endcase
		r.undo_depth = 7'(undo_cnt);
		r.redo_depth = 7'(redo_cnt);
		return r;
	endfunction

	function automatic history_item_t make_item(bur_pkg::mode_t m);
		history_item_t it;
		it.mode  = m;
		it.board = {$urandom, $urandom};
		it.x     = 4'($urandom_range(0, 15));
		it.y     = 4'($urandom_range(0, 15));
		it.moves = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// result side: random or long stalls, compare each item with the oldest prediction
	initial begin
		history_result_t exp_r;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result expected none actual undo_depth %0d",
						$time, undo_depth);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("has_state", 64'(exp_r.has_state), 64'(has_state));
					check_field("refused", 64'(exp_r.refused), 64'(refused));
					check_field("out_board", exp_r.board, out_board);
					check_field("out_x", 64'(exp_r.x), 64'(out_x));
					check_field("out_y", 64'(exp_r.y), 64'(out_y));
					check_field("out_moves", 64'(exp_r.moves), 64'(out_moves));
					check_field("undo_depth", 64'(exp_r.undo_depth), 64'(undo_depth));
					check_field("redo_depth", 64'(exp_r.redo_depth), 64'(redo_depth));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stall_req) begin
				stall_req = 1'b0;
				stall_left = 300;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idling || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	task automatic send_item(history_item_t it);
		if (idling && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= it.mode;
		board_word <= it.board;
		blank_x    <= it.x;
		blank_y    <= it.y;
		moves_made <= it.moves;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_history(it));
	endtask

	task automatic send_mode(bur_pkg::mode_t m);
		send_item(make_item(m));
	endtask

	task automatic push_snapshot(logic [63:0] b, logic [3:0] x, logic [3:0] y,
			logic [15:0] mv);
		history_item_t it;
		it = '{mode: bur_pkg::MODE_PUSH, board: b, x: x, y: y, moves: mv};
		send_item(it);
	endtask

	// stop offering and let every outstanding item come back
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [bur_pkg::CFG_AW-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(logic [bur_pkg::CFG_AW-1:0] addr, logic [31:0] data);
		logic [31:0] unused;
		apb_access(1'b1, addr, data, unused);
		if ((addr >> 2) == bur_pkg::REG_MAX_HISTORY) begin
			hist_limit = data[6:0];
			trim_armed = 1'b1;
		end
	endtask

	task automatic cfg_readback();
		logic [31:0] rd;
		apb_access(1'b0, ADDR_MAX_HISTORY, '0, rd);
		check_field("max_history", {57'd0, hist_limit}, 64'(rd));
	endtask

	task automatic set_history_limit(logic [6:0] lim);
		wait_quiet();
		cfg_write(ADDR_MAX_HISTORY, {25'd0, lim});
		cfg_readback();
	endtask

	task automatic test_basic_ops();
		send_mode(bur_pkg::MODE_UNDO);
		send_mode(bur_pkg::MODE_REDO);
		push_snapshot('1, 4'hf, 4'hf, 16'hffff);
		push_snapshot('0, 4'h0, 4'h0, 16'h0000);
		send_mode(bur_pkg::MODE_UNDO);
		// undo of the only entry left gives no snapshot but is not refused
		send_mode(bur_pkg::MODE_UNDO);
		send_mode(bur_pkg::MODE_REDO);
		send_mode(bur_pkg::MODE_REDO);
		send_mode(bur_pkg::MODE_REDO);
		send_mode(bur_pkg::MODE_PUSH);
		send_mode(bur_pkg::MODE_CLEAR);
		send_mode(bur_pkg::MODE_UNDO);
	endtask

	task automatic test_limit_trim();
		set_history_limit(7'd0);
		repeat (5) send_mode(bur_pkg::MODE_PUSH);
		repeat (2) send_mode(bur_pkg::MODE_UNDO);
		set_history_limit(7'd1);
		// trimmed to one each, then redo lifts undo past the limit
		send_mode(bur_pkg::MODE_REDO);
		send_mode(bur_pkg::MODE_UNDO);
		send_mode(bur_pkg::MODE_UNDO);
		send_mode(bur_pkg::MODE_PUSH);
		send_mode(bur_pkg::MODE_PUSH);
	endtask

	task automatic test_config_register();
		set_history_limit(7'd64);
		wait_quiet();
		cfg_write(ADDR_UNMAPPED, 32'd5);
		cfg_readback();
		set_history_limit(7'd0);
	endtask

	task automatic test_backpressure();
		stall_req = 1'b1;
		repeat (40) send_mode(($urandom_range(0, 99) < 60)
			? bur_pkg::MODE_PUSH : bur_pkg::MODE_UNDO);
		wait_quiet();
	endtask

	task automatic run_phase(logic [6:0] lim, int n_items);
		int done;
		int span;
		int pick;
		int len;
		bit noise;
		bur_pkg::mode_t m;
		set_history_limit(lim);
		span = (lim == 0 || lim > STACK_DEPTH) ? STACK_DEPTH : lim;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(0, 99);
			noise = 1'b0;
			m = bur_pkg::MODE_PUSH;
			if (pick < 40) begin
				len = $urandom_range(1, span + 8);
			end else if (pick < 65) begin
				len = $urandom_range(1, span + 4);
				m = bur_pkg::MODE_UNDO;
			end else if (pick < 88) begin
				len = $urandom_range(1, span + 4);
				m = bur_pkg::MODE_REDO;
			end else if (pick < 92) begin
				len = 1;
				m = bur_pkg::MODE_CLEAR;
			end else begin
				len = $urandom_range(1, 4);
				noise = 1'b1;
			end
			repeat (len) send_mode(noise ? bur_pkg::mode_t'($urandom_range(0, 3)) : m);
			done += len;
		end
	endtask

	task automatic test_random_history();
		int limits [12];
		limits = '{0, 1, 64, 2, 40, 0, -1, 63, -1, 3, 64, 1};
		foreach (limits[i]) begin
			// one phase runs with no idling on either side
			idling = (i != 2);
			run_phase((limits[i] < 0) ? 7'($urandom_range(3, 62)) : 7'(limits[i]), 150);
		end
		idling = 1'b1;
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= bur_pkg::MODE_PUSH;
		board_word <= '0;
		blank_x    <= '0;
		blank_y    <= '0;
		moves_made <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		errors     = 0;
		idling     = 1'b1;
		stall_req  = 1'b0;
		stall_left = 0;
		undo_top   = 0;
		undo_cnt   = 0;
		redo_top   = 0;
		redo_cnt   = 0;
		hist_limit = '0;
		trim_armed = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_limit_trim();
		test_config_register();
		test_backpressure();
		test_random_history();

		wait_quiet();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("bounded_undo_redo_history_top: match");
		else
			$display("bounded_undo_redo_history_top: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/bur_pkg.sv
rtl/bur_ram.sv
rtl/bur_ctrl.sv
rtl/bur_dp.sv
rtl/bounded_undo_redo_history_top.sv
tb/tb_top.sv
